// File: src/arpwol_pkg.sv
// Package for the ARP request wake-on-LAN trigger.
// Holds the transaction payload types and the frame and burst constants.
// No dependencies.
package arpwol_pkg;

    // Number of MAC copies in the magic payload, and the words in one burst.
    localparam int REPEAT_COUNT = 16;
    localparam int WORD_COUNT   = REPEAT_COUNT + 1;
    localparam int CNT_W        = $clog2(WORD_COUNT);

    // Frame offsets.
    localparam int OFF_W           = 6;
    localparam int OFFSET_MAX      = 63;
    localparam int MIN_LAST_OFFSET = 41;

    // Fixed header values.
    localparam logic [7:0] ETYPE_HI  = 8'h08;
    localparam logic [7:0] ETYPE_LO  = 8'h06;
    localparam logic [7:0] OPCODE_HI = 8'h00;
    localparam logic [7:0] OPCODE_LO = 8'h01;
    localparam logic [47:0] SYNC_WORD = 48'hFFFF_FFFF_FFFF;

    // Configuration register indexes, taken from paddr[3].
    localparam logic REG_TARGET_IP  = 1'b0;
    localparam logic REG_TARGET_MAC = 1'b1;

    // Input transaction.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } in_item_t;

    // Output transaction.
    typedef struct packed {
        logic [47:0] payload_word;
        logic        word_last;
    } out_item_t;

endpackage

// File: src/arp_request_wake_on_lan_trigger.sv
// ARP request wake-on-LAN trigger. Accepts one frame byte per cycle while in_ready is
// high. out_valid rises once the frame-end trigger has passed the pending register and
// then the valid register; a burst is 17 words at one per cycle when not stalled.
// Input ready drops only while a second trigger waits behind a running burst.
// Reset (rst_n, asynchronous, active low) clears both registers, the offset to zero,
// the match flag to one, and empties the output side.
module arp_request_wake_on_lan_trigger (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  arpwol_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output arpwol_pkg::out_item_t out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);
    import arpwol_pkg::*;

    logic [31:0] target_ip_reg;
    logic [47:0] target_mac_reg;
    logic        cfg_write;
    logic        in_accept;
    logic        trigger;
    logic        busy_full;

    // Configuration port: registers at byte addresses 0 and 8.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_ip_reg  <= '0;
            target_mac_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3])
                REG_TARGET_IP:  target_ip_reg  <= pwdata[31:0];
                REG_TARGET_MAC: target_mac_reg <= pwdata[47:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            REG_TARGET_IP:  prdata = {32'b0, target_ip_reg};
            REG_TARGET_MAC: prdata = {16'b0, target_mac_reg};
            default:        prdata = '0;
        endcase
    end

    // Input transaction handshake.
    assign in_ready  = ~busy_full;
    assign in_accept = in_valid & in_ready;

    arpwol_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .item      (in_data),
        .target_ip (target_ip_reg),
        .trigger   (trigger)
    );

    arpwol_gen u_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .trigger    (trigger),
        .busy_full  (busy_full),
        .target_mac (target_mac_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

// File: src/arpwol_check.sv
// Frame checker: tracks the byte offset and the header match per frame.
// Depends on arpwol_pkg.
module arpwol_check (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  arpwol_pkg::in_item_t item,
    input  logic [31:0]         target_ip,
    output logic                trigger
);
    import arpwol_pkg::*;

    logic [OFF_W-1:0] offset_reg, offset_next;
    logic             match_reg, match_next;
    logic             mismatch;
    logic             match_now;

    // Compare the byte against the value expected at its offset.
    always_comb
    begin
        unique case (offset_reg)
            6'd12:   mismatch = (item.rx_byte != ETYPE_HI);
            6'd13:   mismatch = (item.rx_byte != ETYPE_LO);
            6'd20:   mismatch = (item.rx_byte != OPCODE_HI);
            6'd21:   mismatch = (item.rx_byte != OPCODE_LO);
            6'd38:   mismatch = (item.rx_byte != target_ip[31:24]);
            6'd39:   mismatch = (item.rx_byte != target_ip[23:16]);
            6'd40:   mismatch = (item.rx_byte != target_ip[15:8]);
            6'd41:   mismatch = (item.rx_byte != target_ip[7:0]);
            default: mismatch = 1'b0;
        endcase
    end

    assign match_now = match_reg & ~mismatch;
    assign trigger   = accept & item.frame_end & match_now
                     & (offset_reg >= OFF_W'(MIN_LAST_OFFSET));

    // Offset saturates on long frames; frame end restarts both.
    always_comb
    begin
        offset_next = offset_reg;
        match_next  = match_reg;
        if (accept)
        begin
            if (item.frame_end)
            begin
                offset_next = '0;
                match_next  = 1'b1;
            end
            else
            begin
                match_next = match_now;
                if (offset_reg != OFF_W'(OFFSET_MAX))
                begin
                    offset_next = offset_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            match_reg  <= 1'b1;
        end
        else
        begin
            offset_reg <= offset_next;
            match_reg  <= match_next;
        end
    end

endmodule

// File: src/arpwol_gen.sv
// Burst generator: holds one waiting trigger and emits the magic payload words.
// Depends on arpwol_pkg.
module arpwol_gen (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  trigger,
    output logic                  busy_full,
    input  logic [47:0]           target_mac,
    output logic                  out_valid,
    input  logic                  out_ready,
    output arpwol_pkg::out_item_t out_data
);
    import arpwol_pkg::*;

    logic             pend_reg, pend_next;
    logic             valid_reg, valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             advance;
    logic             last;
    logic             take;

    assign advance = valid_reg & out_ready;
    assign last    = (cnt_reg == CNT_W'(REPEAT_COUNT));
    // A waiting trigger starts a burst once the output is free.
    assign take    = pend_reg & (~valid_reg | (advance & last));

    // Burst sequencing.
    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        pend_next  = (pend_reg & ~take) | trigger;
        if (take)
        begin
            valid_next = 1'b1;
            cnt_next   = '0;
        end
        else if (advance)
        begin
            if (last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    // The first word is all ones, the rest are copies of the MAC.
    assign out_data.payload_word = (cnt_reg == '0) ? SYNC_WORD : target_mac;
    assign out_data.word_last    = last;
    assign out_valid             = valid_reg;
    // The holding slot frees up in the same cycle as its trigger starts a burst.
    assign busy_full             = pend_reg & ~take;

endmodule
